### design/tca_pkg.sv
// Shared types, sizes and helpers for the threshold cellular automaton grid.
// No dependencies; every other design file except tca_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none

package tca_pkg;

  // Grid geometry
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int CELL_COUNT = MAX_WIDTH * MAX_HEIGHT;
  localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int SIZE_W = $clog2(CELL_COUNT + 1);
  localparam int STEP_W = $clog2(CELL_COUNT + 2);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);

  // Word fields
  localparam int CMD_W     = 2;
  localparam int COORD_W   = 6;
  localparam int COORD_MAX = (1 << COORD_W) - 1;
  localparam int GEN_W     = 32;
  localparam int LIN_W     = $clog2(COORD_MAX * MAX_WIDTH + COORD_MAX + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_DIM_W  = 7;
  localparam int THR_W      = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_THRESHOLD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RULE_ABOVE      = 2'd3;

  localparam logic [CFG_DIM_W-1:0] GRID_WIDTH_RST  = CFG_DIM_W'(64);
  localparam logic [CFG_DIM_W-1:0] GRID_HEIGHT_RST = CFG_DIM_W'(64);
  localparam logic [THR_W-1:0]     THRESHOLD_RST   = THR_W'(5);
  localparam logic                 RULE_ABOVE_RST  = 1'b1;

  // Neighborhood window: three rows of three cells
  localparam int NBR_ROWS   = 3;
  localparam int NBR_ROW_W  = 2;
  localparam int WIN_W      = 3;
  localparam int NBR_CNT_W  = 4;
  localparam int PHASE_W    = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE    = 2'd0,
    CMD_READ     = 2'd1,
    CMD_GENERATE = 2'd2,
    CMD_INVERT   = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_IDX_START,
    ST_IDX_WAIT,
    ST_READ_WAIT,
    ST_COPY,
    ST_COPY_END,
    ST_GEN,
    ST_INV,
    ST_INV_END,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                 cap;
    logic [NBR_ROW_W-1:0] row;
  } win_ctl_t;

  // Zero acts as one, anything above the maximum acts as the maximum.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v,
                                                  input int unsigned maxv);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (int'(v) > int'(maxv)) begin
      res = DIM_W'(maxv);
    end else begin
      res = DIM_W'(v);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### design/tca_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module tca_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### design/tca_mod.sv
// Bit-serial remainder unit: linear cell index modulo the live grid size.
// Depends on tca_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module tca_mod (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [tca_pkg::LIN_W-1:0]   dividend,
  input  logic [tca_pkg::SIZE_W-1:0]  divisor,
  output logic                        done,
  output logic [tca_pkg::ADDR_W-1:0]  rem
);
  import tca_pkg::*;

  localparam int CNT_W = $clog2(LIN_W + 1);

  logic              busy_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [LIN_W-1:0]  sh_r;
  logic [SIZE_W-1:0] rem_r;
  logic [SIZE_W-1:0] div_r;
  logic [SIZE_W:0]   trial;
  logic [SIZE_W:0]   div_ext;

  assign trial   = {rem_r, sh_r[LIN_W-1]};
  assign div_ext = {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(LIN_W);
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end else begin
        busy_r <= 1'b0;
      end
    end
  end

  // One quotient bit per cycle, restoring form
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      sh_r  <= dividend;
      div_r <= divisor;
    end else if (busy_r && (cnt_r != '0)) begin
      rem_r <= (trial >= div_ext) ? SIZE_W'(trial - div_ext) : SIZE_W'(trial);
      sh_r  <= {sh_r[LIN_W-2:0], 1'b0};
    end
  end

  assign done = busy_r && (cnt_r == '0);
  assign rem  = rem_r[ADDR_W-1:0];

endmodule

`default_nettype wire

### design/tca_window.sv
// Sliding 3x3 neighborhood window, neighbor count and threshold rule.
// Depends on tca_pkg for widths and the window control struct.
`timescale 1ns / 1ps
`default_nettype none

module tca_window (
  input  logic                       clk,
  input  tca_pkg::win_ctl_t          ctl,
  input  logic                       snap_bit,
  input  logic [tca_pkg::THR_W-1:0]  threshold,
  input  logic                       rule_above,
  output logic                       alive
);
  import tca_pkg::*;

  logic [WIN_W-1:0]     rows_r [NBR_ROWS];
  logic [WIN_W-1:0]     bottom;
  logic [NBR_CNT_W-1:0] count;

  // Shift the new snapshot bit into the selected row; bit 0 is the newest.
  always_ff @(posedge clk) begin
    if (ctl.cap) begin
      case (ctl.row)
        NBR_ROW_W'(0): rows_r[0] <= {rows_r[0][WIN_W-2:0], snap_bit};
        NBR_ROW_W'(1): rows_r[1] <= {rows_r[1][WIN_W-2:0], snap_bit};
        NBR_ROW_W'(2): rows_r[2] <= {rows_r[2][WIN_W-2:0], snap_bit};
        default: ;
      endcase
    end
  end

  // Bottom row is completed by the bit arriving in the same cycle.
  assign bottom = {rows_r[2][WIN_W-2:0], snap_bit};

  always_comb begin
    count = '0;
    for (int i = 0; i < WIN_W; i++) begin
      count = count + NBR_CNT_W'(rows_r[0][i]) + NBR_CNT_W'(bottom[i]);
    end
    count = count + NBR_CNT_W'(rows_r[1][0]) + NBR_CNT_W'(rows_r[1][WIN_W-1]);
  end

  assign alive = rule_above ? (count > threshold) : (count <= threshold);

endmodule

`default_nettype wire

### design/threshold_cellular_automaton_grid.sv
// Top level of the threshold cellular automaton grid: command sequencer,
// cell and snapshot memories. Depends on tca_pkg, tca_ram, tca_mod, tca_window.
`timescale 1ns / 1ps
`default_nettype none

//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_stall  | in_cmd, in_cell_x, in_cell_y, in_cell_value
//  out     | out_valid / out_stall| out_read_bit, out_generation_count
//  cfg     | cfg_we               | cfg_index, cfg_wdata
//
//  One command word is in flight at a time; S = width * height of the live area.
//  Write and read are dominated by the 12-bit serial modulo.
//  Invert does one read-modify-write per cell on the cell memory.
//  Generation first copies the cell memory into the snapshot memory, then
//  visits each cell in phases, since the single snapshot read port serves
//  three neighbor rows. After reset a clearing pass zeroes the cell memory;
//  in_stall stays high until it ends. The result register lets the next
//  word be accepted while a result waits under out_stall.

module threshold_cellular_automaton_grid (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tca_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tca_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [tca_pkg::CMD_W-1:0]       in_cmd,
  input  logic [tca_pkg::COORD_W-1:0]     in_cell_x,
  input  logic [tca_pkg::COORD_W-1:0]     in_cell_y,
  input  logic                            in_cell_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_read_bit,
  output logic [tca_pkg::GEN_W-1:0]       out_generation_count
);
  import tca_pkg::*;

  // Sequencer state
  state_t state_r, state_nxt;

  // Configuration registers
  logic [CFG_DIM_W-1:0] cfg_w_r;
  logic [CFG_DIM_W-1:0] cfg_h_r;
  logic [THR_W-1:0]     cfg_thr_r;
  logic                 cfg_rule_r;

  // Captured command word
  cmd_t               cmd_r;
  logic [COORD_W-1:0] x_r;
  logic [COORD_W-1:0] y_r;
  logic               val_r;

  // Per-command geometry
  logic [DIM_W-1:0]  w_eff, h_eff;
  logic [DIM_W-1:0]  w_r;
  logic [SIZE_W-1:0] s_r;
  logic [SIZE_W-1:0] w_ext;
  logic [LIN_W-1:0]  lin_r;
  logic [ADDR_W-1:0] s_last;

  // Sweep counter and pending write-back
  logic [ADDR_W-1:0] k_r;
  logic              last_k;
  logic              pend_v_r;
  logic [ADDR_W-1:0] pend_a_r;

  // Generation pass
  logic [ADDR_W-1:0]  pa_r [NBR_ROWS];
  logic [PHASE_W-1:0] phase_r;
  logic [STEP_W-1:0]  step_r;
  logic               ph_last;
  logic               gen_last;
  logic               gen_wr;
  logic [ADDR_W-1:0]  gen_addr;
  win_ctl_t           win_ctl;
  logic               alive;

  // Counters and result
  logic [GEN_W-1:0] gen_cnt_r;
  logic             res_bit_r;
  logic             out_valid_r;
  logic             out_bit_r;
  logic [GEN_W-1:0] out_gen_r;
  logic             slot_free;
  logic             in_acc;

  // Index unit
  logic              mod_start;
  logic              mod_done;
  logic [ADDR_W-1:0] mod_rem;

  // Memory ports
  logic              cell_we, cell_wdata, cell_rdata;
  logic [ADDR_W-1:0] cell_waddr, cell_raddr;
  logic              snap_we, snap_wdata, snap_rdata;
  logic [ADDR_W-1:0] snap_waddr, snap_raddr;

  assign w_eff     = clamp_dim(cfg_w_r, MAX_WIDTH);
  assign h_eff     = clamp_dim(cfg_h_r, MAX_HEIGHT);
  assign w_ext     = SIZE_W'(w_r);
  assign s_last    = ADDR_W'(s_r - 1'b1);
  assign last_k    = (k_r == s_last);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  assign ph_last  = (phase_r == PHASE_W'(NBR_ROWS));
  assign gen_last = ph_last && (step_r == STEP_W'(s_r) + STEP_W'(1));
  assign gen_wr   = ph_last && (step_r >= STEP_W'(2));
  assign gen_addr = ADDR_W'(step_r - STEP_W'(2));

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (k_r == ADDR_W'(CELL_COUNT - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        case (cmd_r)
          CMD_GENERATE: state_nxt = ST_COPY;
          CMD_INVERT:   state_nxt = ST_INV;
          default:      state_nxt = ST_IDX_START;
        endcase
      end
      ST_IDX_START: state_nxt = ST_IDX_WAIT;
      ST_IDX_WAIT: begin
        if (mod_done) state_nxt = (cmd_r == CMD_READ) ? ST_READ_WAIT : ST_DONE;
      end
      ST_READ_WAIT: state_nxt = ST_DONE;
      ST_COPY: begin
        if (last_k) state_nxt = ST_COPY_END;
      end
      ST_COPY_END: state_nxt = ST_GEN;
      ST_GEN: begin
        if (gen_last) state_nxt = ST_DONE;
      end
      ST_INV: begin
        if (last_k) state_nxt = ST_INV_END;
      end
      ST_INV_END: state_nxt = ST_DONE;
      ST_DONE: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Outputs: handshake, memory ports, index unit start, window control
  // ---------------------------------------------------------------------------
  always_comb begin
    in_stall    = (state_r != ST_IDLE);
    mod_start   = 1'b0;
    cell_we     = 1'b0;
    cell_waddr  = pend_a_r;
    cell_wdata  = 1'b0;
    cell_raddr  = k_r;
    snap_we     = 1'b0;
    snap_waddr  = pend_a_r;
    snap_wdata  = cell_rdata;
    snap_raddr  = pa_r[0];
    win_ctl.cap = 1'b0;
    win_ctl.row = '0;
    case (state_r)
      ST_CLEAR: begin
        // zero one cell per cycle
        cell_we    = 1'b1;
        cell_waddr = k_r;
      end
      ST_IDX_START: mod_start = 1'b1;
      ST_IDX_WAIT: begin
        cell_raddr = mod_rem;
        if (mod_done && (cmd_r == CMD_WRITE)) begin
          cell_we    = 1'b1;
          cell_waddr = mod_rem;
          cell_wdata = val_r;
        end
      end
      ST_COPY, ST_COPY_END: snap_we = pend_v_r;
      ST_INV, ST_INV_END: begin
        // write back the inverse of the cell read last cycle
        cell_we    = pend_v_r;
        cell_wdata = ~cell_rdata;
      end
      ST_GEN: begin
        for (int r = 0; r < NBR_ROWS; r++) begin
          if (phase_r == PHASE_W'(r)) snap_raddr = pa_r[r];
        end
        win_ctl.cap = (phase_r != '0);
        win_ctl.row = NBR_ROW_W'(phase_r - 1'b1);
        if (gen_wr) begin
          cell_we    = 1'b1;
          cell_waddr = gen_addr;
          cell_wdata = alive;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cfg_w_r     <= GRID_WIDTH_RST;
      cfg_h_r     <= GRID_HEIGHT_RST;
      cfg_thr_r   <= THRESHOLD_RST;
      cfg_rule_r  <= RULE_ABOVE_RST;
      k_r         <= '0;
      pend_v_r    <= 1'b0;
      phase_r     <= '0;
      step_r      <= '0;
      gen_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_index)
          CFG_GRID_WIDTH:      cfg_w_r    <= cfg_wdata[CFG_DIM_W-1:0];
          CFG_GRID_HEIGHT:     cfg_h_r    <= cfg_wdata[CFG_DIM_W-1:0];
          CFG_COUNT_THRESHOLD: cfg_thr_r  <= cfg_wdata[THR_W-1:0];
          CFG_RULE_ABOVE:      cfg_rule_r <= cfg_wdata[0];
          default: ;
        endcase
      end

      // sweep counter: clearing pass, copy and invert
      case (state_r)
        ST_CLEAR: begin
          k_r <= (k_r == ADDR_W'(CELL_COUNT - 1)) ? '0 : k_r + 1'b1;
        end
        ST_COPY, ST_INV: begin
          k_r <= last_k ? '0 : k_r + 1'b1;
        end
        default: k_r <= '0;
      endcase

      pend_v_r <= (state_r inside {ST_COPY, ST_INV});

      // generation phase and step
      case (state_r)
        ST_COPY_END: begin
          phase_r <= '0;
          step_r  <= '0;
        end
        ST_GEN: begin
          if (ph_last) begin
            phase_r <= '0;
            step_r  <= step_r + 1'b1;
          end else begin
            phase_r <= phase_r + 1'b1;
          end
        end
        default: ;
      endcase

      if ((state_r == ST_GEN) && gen_last) begin
        gen_cnt_r <= gen_cnt_r + 1'b1;
      end

      // hold the result while stalled, drop it once taken
      if ((state_r == ST_DONE) && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r     <= cmd_t'(in_cmd);
      x_r       <= in_cell_x;
      y_r       <= in_cell_y;
      val_r     <= in_cell_value;
      res_bit_r <= 1'b0;
    end

    if (state_r == ST_SETUP) begin
      w_r   <= w_eff;
      s_r   <= SIZE_W'(SIZE_W'(w_eff) * SIZE_W'(h_eff));
      lin_r <= LIN_W'(y_r) * LIN_W'(w_eff) + LIN_W'(x_r);
    end

    if (state_r == ST_READ_WAIT) begin
      res_bit_r <= cell_rdata;
    end

    pend_a_r <= k_r;

    // Row pointers start one cell left of the rows above, at and below cell 0,
    // all wrapped on the linear index.
    if (state_r == ST_COPY_END) begin
      pa_r[0] <= (s_r > w_ext) ? ADDR_W'(s_r - w_ext - 1'b1) : s_last;
      pa_r[1] <= s_last;
      pa_r[2] <= ADDR_W'(w_r - 1'b1);
    end else if (state_r == ST_GEN) begin
      for (int r = 0; r < NBR_ROWS; r++) begin
        if (phase_r == PHASE_W'(r)) begin
          pa_r[r] <= (pa_r[r] == s_last) ? '0 : pa_r[r] + 1'b1;
        end
      end
    end

    if ((state_r == ST_DONE) && slot_free) begin
      out_bit_r <= res_bit_r;
      out_gen_r <= gen_cnt_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_read_bit         = out_bit_r;
  assign out_generation_count = out_gen_r;

  // ---------------------------------------------------------------------------
  // Submodules
  // ---------------------------------------------------------------------------
  tca_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (lin_r),
    .divisor  (s_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  tca_ram #(
    .WIDTH (1),
    .DEPTH (CELL_COUNT)
  ) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  tca_ram #(
    .WIDTH (1),
    .DEPTH (CELL_COUNT)
  ) u_snap_ram (
    .clk   (clk),
    .we    (snap_we),
    .waddr (snap_waddr),
    .wdata (snap_wdata),
    .raddr (snap_raddr),
    .rdata (snap_rdata)
  );

  tca_window u_window (
    .clk        (clk),
    .ctl        (win_ctl),
    .snap_bit   (snap_rdata),
    .threshold  (cfg_thr_r),
    .rule_above (cfg_rule_r),
    .alive      (alive)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_accept_setup: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == ST_SETUP)
    else $error("accepted word did not enter setup");

  a_gen_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (gen_cnt_r != $past(gen_cnt_r)) |->
      (gen_cnt_r == $past(gen_cnt_r) + 1'b1) && ($past(state_r) == ST_GEN))
    else $error("generation count moved outside a generation end");

  a_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> SIZE_W'(mod_rem) < s_r)
    else $error("cell index not below grid size");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_GEN |-> (pa_r[0] <= s_last) && (pa_r[1] <= s_last) && (pa_r[2] <= s_last))
    else $error("row pointer left the live area");

endmodule

`default_nettype wire
